[rtl/sdtq_pkg.sv]
// sdtq_pkg: shared widths, codes and types of the sorted delay timer queue
// no dependencies; imported by the interfaces, the queue cell and the top level
package sdtq_pkg;

   localparam int unsigned QUEUE_DEPTH = 16;

   localparam int unsigned OP_W     = 2;
   localparam int unsigned ID_W     = 8;
   localparam int unsigned PRIO_W   = 8;
   localparam int unsigned DELAY_W  = 32;
   localparam int unsigned TICK_W   = 64;
   localparam int unsigned STATUS_W = 2;

   // operation codes of a request
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   // status codes of a response
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NONE      = 2'd3;

   typedef struct packed {
      logic [TICK_W-1:0] deadline;
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      valid;
   } slot_type;

   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_SHIFT
   } cmd_type;

   // broadcast from the controller to every cell
   typedef struct packed {
      cmd_type           cmd;
      entry_type         key;
      logic [TICK_W-1:0] tick;
   } bcast_type;

endpackage

[rtl/sdtq_if.sv]
// request and response channel interfaces of the sorted delay timer queue
// depends on sdtq_pkg for field widths
interface sdtq_req_if import sdtq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [ID_W-1:0]    task_id;
   logic [PRIO_W-1:0]  task_priority;
   logic [DELAY_W-1:0] delay_ticks;

   modport source (output valid, op, task_id, task_priority, delay_ticks, input ready);
   modport sink   (input valid, op, task_id, task_priority, delay_ticks, output ready);
endinterface

interface sdtq_rsp_if import sdtq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                released_valid;
   logic [ID_W-1:0]     released_id;
   logic [PRIO_W-1:0]   released_priority;
   logic [TICK_W-1:0]   tick_now;
   logic                last;

   modport source (output valid, status, released_valid, released_id, released_priority,
                   tick_now, last, input ready);
   modport sink   (input valid, status, released_valid, released_id, released_priority,
                   tick_now, last, output ready);
endinterface

[rtl/sorted_delay_timer_queue.sv]
// sorted_delay_timer_queue: hardware delay queue of waiting tasks, sorted by deadline
// depends on sdtq_pkg, sdtq_req_if / sdtq_rsp_if and sdtq_cell
//
//   channel  dir  handshake          transaction
//   req_chan in   valid / ready      op, task_id, task_priority, delay_ticks
//   rsp_chan out  valid / ready      status, released_*, tick_now, last
//
// insert (if not full) and remove update the whole cell row at the accepting edge
// tick: the accepting edge advances the counter, then each response pops one due head;
//   with none due it answers status none (one head compare a cycle while output is free)
// reset (synchronous) empties the queue and clears the tick counter; no clearing pass
// a stalled response holds in its output register; the next request is taken as soon as
//   the queue is idle and the output register is free or being emptied in the same cycle
module sorted_delay_timer_queue import sdtq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   sdtq_req_if.sink   req_chan,
   sdtq_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      S_IDLE    = 2'b01,
      S_RELEASE = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [TICK_W-1:0] tick_ff, tick_in;

   // response output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_rel_valid_ff, rsp_rel_valid_in;
   logic [ID_W-1:0]     rsp_rel_id_ff, rsp_rel_id_in;
   logic [PRIO_W-1:0]   rsp_rel_prio_ff, rsp_rel_prio_in;
   logic [TICK_W-1:0]   rsp_tick_ff, rsp_tick_in;
   logic                rsp_last_ff, rsp_last_in;

   logic out_free;
   logic accept;

   // cell row
   bcast_type              bcast;
   cmd_type                bcast_cmd;
   slot_type               cell_slot [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH-1:0] cell_ins;
   logic [QUEUE_DEPTH-1:0] cell_due;
   logic [QUEUE_DEPTH:0]   hit_chain;
   logic                   next_due;
   logic                   full;
   logic                   found;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_chan.ready;

   assign full  = cell_valid[QUEUE_DEPTH-1];
   assign found = hit_chain[QUEUE_DEPTH];
   assign hit_chain[0] = 1'b0;

   // new entry and key, both taken from the request; deadline wraps modulo 2^64
   assign bcast = '{cmd:  bcast_cmd,
                    key:  '{deadline: tick_ff + TICK_W'(req_chan.delay_ticks),
                            id:       req_chan.task_id,
                            prio:     req_chan.task_priority},
                    tick: tick_ff};

   // row of cells, head at index 0
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      slot_type left_slot, right_slot;
      logic     left_ins;

      if (i == 0) begin : g_head
         assign left_slot = '0;
         assign left_ins  = 1'b0;
      end else begin : g_mid
         assign left_slot = cell_slot[i-1];
         assign left_ins  = cell_ins[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_slot = '{entry: cell_slot[i].entry, valid: 1'b0};
      end else begin : g_body
         assign right_slot = cell_slot[i+1];
      end

      sdtq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .bcast      (bcast),
         .left_slot  (left_slot),
         .left_ins   (left_ins),
         .right_slot (right_slot),
         .hit_in     (hit_chain[i]),
         .slot       (cell_slot[i]),
         .ins_here   (cell_ins[i]),
         .hit_out    (hit_chain[i+1]),
         .due        (cell_due[i])
      );

      assign cell_valid[i] = cell_slot[i].valid;
   end

   // whether the entry behind the head is due too, which decides last
   if (QUEUE_DEPTH > 1) begin : g_next
      assign next_due = cell_due[1];
   end else begin : g_single
      assign next_due = 1'b0;
   end

   always_comb begin
      state_in         = state_ff;
      tick_in          = tick_ff;
      bcast_cmd        = CMD_HOLD;
      rsp_valid_in     = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in    = rsp_status_ff;
      rsp_rel_valid_in = rsp_rel_valid_ff;
      rsp_rel_id_in    = rsp_rel_id_ff;
      rsp_rel_prio_in  = rsp_rel_prio_ff;
      rsp_tick_in      = rsp_tick_ff;
      rsp_last_in      = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               // common shape of a single non-release response
               rsp_status_in    = ST_NOT_FOUND;
               rsp_rel_valid_in = 1'b0;
               rsp_rel_id_in    = '0;
               rsp_rel_prio_in  = '0;
               rsp_tick_in      = tick_ff;
               rsp_last_in      = 1'b1;
               rsp_valid_in     = 1'b1;
               case (req_chan.op)
                  OP_TICK: begin
                     tick_in      = tick_ff + 1'b1;
                     rsp_valid_in = 1'b0;
                     state_in     = S_RELEASE;
                  end
                  OP_INSERT: begin
                     if (full) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        bcast_cmd     = CMD_INSERT;
                        rsp_status_in = ST_OK;
                     end
                  end
                  OP_REMOVE: begin
                     bcast_cmd     = CMD_REMOVE;
                     rsp_status_in = found ? ST_OK : ST_NOT_FOUND;
                  end
                  default: begin
                     rsp_status_in = ST_NOT_FOUND;
                  end
               endcase
            end
         end
         S_RELEASE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_tick_in  = tick_ff;
               if (cell_due[0]) begin
                  // pop the head and hand it out
                  bcast_cmd        = CMD_SHIFT;
                  rsp_status_in    = ST_OK;
                  rsp_rel_valid_in = 1'b1;
                  rsp_rel_id_in    = cell_slot[0].entry.id;
                  rsp_rel_prio_in  = cell_slot[0].entry.prio;
                  rsp_last_in      = !next_due;
                  if (!next_due) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  // only reached on the walk's first head compare: nothing expired
                  rsp_status_in    = ST_NONE;
                  rsp_rel_valid_in = 1'b0;
                  rsp_rel_id_in    = '0;
                  rsp_rel_prio_in  = '0;
                  rsp_last_in      = 1'b1;
                  state_in         = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff    <= rsp_status_in;
      rsp_rel_valid_ff <= rsp_rel_valid_in;
      rsp_rel_id_ff    <= rsp_rel_id_in;
      rsp_rel_prio_ff  <= rsp_rel_prio_in;
      rsp_tick_ff      <= rsp_tick_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_chan.valid             = rsp_valid_ff;
   assign rsp_chan.status            = rsp_status_ff;
   assign rsp_chan.released_valid    = rsp_rel_valid_ff;
   assign rsp_chan.released_id       = rsp_rel_id_ff;
   assign rsp_chan.released_priority = rsp_rel_prio_ff;
   assign rsp_chan.tick_now          = rsp_tick_ff;
   assign rsp_chan.last              = rsp_last_ff;

   // occupied cells always form a solid run from the head
   a_valid_packed: assert property (@(posedge clock) disable iff (reset)
      ((cell_valid & (cell_valid + 1'b1)) == '0))
      else $error("queue occupancy has a hole");

   // a tick request advances the counter by one and starts the release walk
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.op == OP_TICK)) |=>
         ((state_ff == S_RELEASE) && (tick_ff == $past(tick_ff) + 1'b1)))
      else $error("tick did not advance the counter");

   // an insert into a full queue leaves the row untouched
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_chan.op == OP_INSERT) && full) |=> $stable(cell_valid))
      else $error("insert into full queue changed occupancy");

   // a released task always comes with status ok
   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rel_valid_ff) |-> (rsp_status_ff == ST_OK))
      else $error("release response with bad status");

endmodule

[rtl/sdtq_cell.sv]
// sdtq_cell: one slot of the sorted queue chain
// depends on sdtq_pkg; instantiated in a row by sorted_delay_timer_queue
module sdtq_cell import sdtq_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  bcast_type bcast,
   input  slot_type  left_slot,
   input  logic      left_ins,
   input  slot_type  right_slot,
   input  logic      hit_in,
   output slot_type  slot,
   output logic      ins_here,
   output logic      hit_out,
   output logic      due
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;
   logic      after_key;

   // this entry sorts strictly behind the new one
   assign after_key = (entry_ff.deadline > bcast.key.deadline) ||
                      ((entry_ff.deadline == bcast.key.deadline) &&
                       (entry_ff.prio < bcast.key.prio));
   assign ins_here  = !valid_ff || after_key;
   assign hit_out   = hit_in || (valid_ff && (entry_ff.id == bcast.key.id));
   assign due       = valid_ff && (entry_ff.deadline <= bcast.tick);
   assign slot      = '{entry: entry_ff, valid: valid_ff};

   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      case (bcast.cmd)
         CMD_INSERT: begin
            if (left_ins) begin
               entry_in = left_slot.entry;
               valid_in = left_slot.valid;
            end else if (ins_here) begin
               entry_in = bcast.key;
               valid_in = 1'b1;
            end
         end
         CMD_REMOVE: begin
            if (hit_out) begin
               entry_in = right_slot.entry;
               valid_in = right_slot.valid;
            end
         end
         CMD_SHIFT: begin
            entry_in = right_slot.entry;
            valid_in = right_slot.valid;
         end
         default: begin
            entry_in = entry_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
